// ----- rtl/priority_job_queue_with_timer_defines.svh -----
// ----------------------------------------------------------------------------
// Priority job queue assertion macros
// Shared property shorthands for the queue's checker; clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_JOB_QUEUE_WITH_TIMER_DEFINES_SVH
`define PRIORITY_JOB_QUEUE_WITH_TIMER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PJQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define PJQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pjq_pkg.sv -----
// ----------------------------------------------------------------------------
// Priority job queue package
// Opcodes, status codes, command and result types shared by the queue blocks.
// ----------------------------------------------------------------------------
package pjq_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_FINISHED = 3'd2;
    localparam logic [2:0] ST_PRINTING = 3'd3;
    localparam logic [2:0] ST_IDLE     = 3'd4;

    localparam logic [7:0] TIMER_RESET = 8'd5;

    // Command queue between front and back: 2**FIFO_AW entries
    localparam int FIFO_AW    = 1;
    localparam int FIFO_DEPTH = 2 ** FIFO_AW;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_TICK,
        CMD_CLEAR,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] tag;
        logic [1:0]  level;
    } cmd_t;

    typedef struct packed {
        logic        done;
        logic [2:0]  status;
        logic [15:0] finished_tag;
        logic        current_valid;
        logic [15:0] current_tag;
        logic [1:0]  current_level;
        logic [7:0]  ticks_left;
        logic [5:0]  queue_count;
    } res_t;

endpackage

// ----- rtl/priority_job_queue_with_timer.sv -----
// ----------------------------------------------------------------------------
// Priority job queue with timer
// Four-level print job queue: append, clear, timed finish of the oldest top job.
// ----------------------------------------------------------------------------
// An add, clear or non-finishing tick passes through the front stage, the FIFO and the
// back section's top scan (S_TOP); a finishing tick adds the S_FIND and S_SHIFT passes.
// New items are taken while the back section works on an earlier one, until the buffers
// fill; the entry memory's single read port scans one entry a cycle.
// Up to three items are buffered ahead of the back section; results cannot stall.
// Reset: queue empty, job timer and job_duration 5, no clearing pass.
module priority_job_queue_with_timer
    import pjq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] job_tag,
    input  logic [1:0]  job_level,
    input  logic        cfg_write,
    input  logic [7:0]  job_duration,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] finished_tag,
    output logic        current_valid,
    output logic [15:0] current_tag,
    output logic [1:0]  current_level,
    output logic [7:0]  ticks_left,
    output logic [5:0]  queue_count
);

    logic [7:0] duration_reg;
    logic       fifo_full;
    logic       fifo_empty;
    logic       push;
    logic       pop;
    cmd_t       push_data;
    cmd_t       pop_data;
    res_t       res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg <= TIMER_RESET;
        end
        else if (cfg_write)
        begin
            duration_reg <= job_duration;
        end
    end

    pjq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .job_tag   (job_tag),
        .job_level (job_level),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    pjq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    pjq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .cmd        (pop_data),
        .pop        (pop),
        .duration   (duration_reg),
        .res        (res)
    );

    assign done          = res.done;
    assign status        = res.status;
    assign finished_tag  = res.finished_tag;
    assign current_valid = res.current_valid;
    assign current_tag   = res.current_tag;
    assign current_level = res.current_level;
    assign ticks_left    = res.ticks_left;
    assign queue_count   = res.queue_count;

endmodule

// ----- rtl/pjq_fifo.sv -----
// ----------------------------------------------------------------------------
// Priority job queue command FIFO
// Short queue of decoded commands between the front and back sections.
// ----------------------------------------------------------------------------
module pjq_fifo
    import pjq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t pop_data,
    output logic full,
    output logic empty
);

    cmd_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   cnt_reg;

    assign full     = (cnt_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (FIFO_AW + 1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (FIFO_AW + 1)'(1);
            end
        end
    end

endmodule

// ----- rtl/pjq_front.sv -----
// ----------------------------------------------------------------------------
// Priority job queue front section
// Accepts items, decodes the opcode into a command and feeds the FIFO.
// ----------------------------------------------------------------------------
module pjq_front
    import pjq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] job_tag,
    input  logic [1:0]  job_level,
    input  logic        fifo_full,
    output logic        push,
    output cmd_t        push_data
);

    logic stage_valid_reg;
    cmd_t stage_cmd_reg;
    cmd_t decoded;
    logic accept;

    always_comb
    begin
        decoded = '{kind: CMD_NOP, tag: 16'd0, level: 2'd0};
        unique case (opcode)
            OP_ADD:
            begin
                decoded.kind  = CMD_ADD;
                decoded.tag   = job_tag;
                decoded.level = job_level;
            end
            OP_TICK:  decoded.kind = CMD_TICK;
            OP_CLEAR: decoded.kind = CMD_CLEAR;
            default:  decoded.kind = CMD_NOP;
        endcase
    end

    assign push      = stage_valid_reg && !fifo_full;
    assign busy      = stage_valid_reg && fifo_full;
    assign accept    = start && !busy;
    assign push_data = stage_cmd_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_cmd_reg <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- rtl/pjq_back.sv -----
// ----------------------------------------------------------------------------
// Priority job queue back section
// Runs commands on the entry memory: append, timer, top search, shift, clear.
// ----------------------------------------------------------------------------
module pjq_back
    import pjq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fifo_empty,
    input  cmd_t       cmd,
    output logic       pop,
    input  logic [7:0] duration,
    output res_t       res
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_SHIFT,
        S_TOP
    } state_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [1:0]  level;
    } entry_t;

    entry_t entry_mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       timer_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [15:0]      best_tag_reg;
    logic [1:0]       best_lvl_reg;
    logic [2:0]       status_reg;
    logic [15:0]      fin_tag_reg;
    res_t             res_reg;

    logic [7:0]       t_dec;
    logic             finish;
    logic             issue;
    logic             upd;
    logic             last;
    logic [IDX_W-1:0] best_idx_new;
    logic [15:0]      best_tag_new;
    logic [1:0]       best_lvl_new;
    logic             not_full;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;

    always_comb
    begin
        t_dec    = (timer_reg != 8'd0) ? timer_reg - 8'd1 : 8'd0;
        finish   = (count_reg != '0) && (t_dec == 8'd0);
        not_full = (count_reg < CNT_W'(QUEUE_DEPTH));
        pop      = (state_reg == S_IDLE) && !fifo_empty;
        issue    = (state_reg != S_IDLE) && (ptr_reg < count_reg);

        // Running maximum; first entry always taken, ties keep the older one
        upd  = pend_reg && ((pend_idx_reg == '0) || (rd_data_reg.level > best_lvl_reg));
        last = pend_reg && (CNT_W'(pend_idx_reg) == count_reg - CNT_W'(1));
        best_idx_new = upd ? pend_idx_reg : best_idx_reg;
        best_tag_new = upd ? rd_data_reg.tag : best_tag_reg;
        best_lvl_new = upd ? rd_data_reg.level : best_lvl_reg;

        we    = 1'b0;
        waddr = count_reg[IDX_W-1:0];
        wdata = '{tag: cmd.tag, level: cmd.level};
        if (pop && (cmd.kind == CMD_ADD) && not_full)
        begin
            we = 1'b1;
        end
        else if ((state_reg == S_SHIFT) && pend_reg)
        begin
            // Move entry up by one to close the gap
            we    = 1'b1;
            waddr = pend_idx_reg - IDX_W'(1);
            wdata = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
        rd_data_reg <= entry_mem[ptr_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            timer_reg    <= TIMER_RESET;
            ptr_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            best_idx_reg <= '0;
            best_tag_reg <= '0;
            best_lvl_reg <= '0;
            status_reg   <= ST_IDLE;
            fin_tag_reg  <= '0;
            res_reg      <= '0;
        end
        else
        begin
            res_reg.done <= (state_reg == S_TOP) && ((count_reg == '0) || last);
            pend_reg     <= issue;
            if (issue)
            begin
                pend_idx_reg <= ptr_reg[IDX_W-1:0];
                ptr_reg      <= ptr_reg + CNT_W'(1);
            end
            best_idx_reg <= best_idx_new;
            best_tag_reg <= best_tag_new;
            best_lvl_reg <= best_lvl_new;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        fin_tag_reg <= '0;
                        ptr_reg     <= '0;
                        state_reg   <= ((cmd.kind == CMD_TICK) && finish) ? S_FIND : S_TOP;
                        unique case (cmd.kind)
                            CMD_ADD:
                            begin
                                if (not_full)
                                begin
                                    count_reg  <= count_reg + CNT_W'(1);
                                    status_reg <= ST_ADDED;
                                end
                                else
                                begin
                                    status_reg <= ST_DROPPED;
                                end
                            end
                            CMD_TICK:
                            begin
                                if (finish)
                                begin
                                    timer_reg  <= duration;
                                    status_reg <= ST_FINISHED;
                                end
                                else
                                begin
                                    timer_reg  <= t_dec;
                                    status_reg <= (count_reg != '0) ? ST_PRINTING : ST_IDLE;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                count_reg  <= '0;
                                status_reg <= ST_IDLE;
                            end
                            default:
                            begin
                                status_reg <= (count_reg != '0) ? ST_PRINTING : ST_IDLE;
                            end
                        endcase
                    end
                end
                S_FIND:
                begin
                    if (last)
                    begin
                        fin_tag_reg <= best_tag_new;
                        ptr_reg     <= CNT_W'(best_idx_new) + CNT_W'(1);
                        state_reg   <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    if ((ptr_reg >= count_reg) && !pend_reg)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        ptr_reg   <= '0;
                        state_reg <= S_TOP;
                    end
                end
                S_TOP:
                begin
                    if ((count_reg == '0) || last)
                    begin
                        res_reg.status        <= status_reg;
                        res_reg.finished_tag  <= fin_tag_reg;
                        res_reg.current_valid <= (count_reg != '0);
                        res_reg.current_tag   <= (count_reg != '0) ? best_tag_new : 16'd0;
                        res_reg.current_level <= (count_reg != '0) ? best_lvl_new : 2'd0;
                        res_reg.ticks_left    <= timer_reg;
                        res_reg.queue_count   <= 6'(count_reg);
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

// ----- rtl/pjq_checker.sv -----
// ----------------------------------------------------------------------------
// Priority job queue checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_job_queue_with_timer_defines.svh"

module pjq_checker
    import pjq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic [2:0]  status,
    input logic [15:0] finished_tag,
    input logic        current_valid,
    input logic [15:0] current_tag,
    input logic [1:0]  current_level,
    input logic [5:0]  queue_count
);

    // A result with no current job shows an empty queue and zero job fields
    `PJQ_ASSERT_IMPL(a_empty_fields, done && !current_valid,
        (queue_count == 6'd0) && (current_tag == 16'd0) && (current_level == 2'd0),
        "empty queue shows a current job")

    // Only a finishing tick reports a finished tag
    `PJQ_ASSERT_IMPL(a_fin_tag_zero, done && (status != ST_FINISHED),
        finished_tag == 16'd0, "finished tag on a non-finish result")

    // Added job or printing status means the queue is not empty
    `PJQ_ASSERT_IMPL(a_added_valid,
        done && ((status == ST_ADDED) || (status == ST_PRINTING)),
        current_valid, "queue empty after add or while printing")

    // Result strobes never come back to back
    `PJQ_ASSERT_NEXT(a_done_gap, done, !done, "back-to-back result strobes")

endmodule

bind priority_job_queue_with_timer pjq_checker u_pjq_checker (.*);
